FILE: hdl/rau_pkg.sv
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int WIDE_W        = 64;
    localparam int EXT_SHIFT     = FIELD_W - OPERAND_WIDTH;
    localparam int CNT_W         = $clog2(WIDE_W);

    localparam logic [WIDE_W-1:0] FIT_LIM = 64'd1 << (OPERAND_WIDTH - 1);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_GZERO = 2'd1;
    localparam logic [1:0] ST_OVF   = 2'd2;

    localparam logic [1:0] MUL_S0 = 2'd0;
    localparam logic [1:0] MUL_S1 = 2'd1;
    localparam logic [1:0] MUL_S2 = 2'd2;

    localparam logic [1:0] DIV_EUC = 2'd0;
    localparam logic [1:0] DIV_NUM = 2'd1;
    localparam logic [1:0] DIV_DEN = 2'd2;

    typedef struct packed {
        logic       neg;
        logic [FIELD_W-1:0] mag;
    } operand_t;

    typedef struct packed {
        logic       load_in;
        logic       mul_load;
        logic [1:0] mul_step;
        logic       comb_load;
        logic       div_start;
        logic [1:0] div_sel;
        logic       euc_step;
        logic       g_load;
        logic       qn_load;
        logic       qd_load;
        logic       out_load;
        logic       out_gz;
    } cmd_t;

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic div_done;
    } sts_t;

    function automatic operand_t load_operand(logic [FIELD_W-1:0] raw);
        logic signed [FIELD_W-1:0] sv;
        operand_t r;
        sv    = $signed(raw << EXT_SHIFT) >>> EXT_SHIFT;
        r.neg = sv[FIELD_W-1];
        r.mag = sv[FIELD_W-1] ? (~sv + 1'b1) : sv;
        return r;
    endfunction

endpackage

FILE: hdl/rau_divider.sv
module rau_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rau_pkg::WIDE_W-1:0]    dividend,
    input  logic [rau_pkg::WIDE_W-1:0]    divisor,
    output logic                          done,
    output logic [rau_pkg::WIDE_W-1:0]    quot,
    output logic [rau_pkg::WIDE_W-1:0]    rem
);
    import rau_pkg::*;

    localparam logic [1:0] D_IDLE   = 2'd0;
    localparam logic [1:0] D_ALIGN  = 2'd1;
    localparam logic [1:0] D_REDUCE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  k_reg;
    logic [WIDE_W-1:0] r_reg, d_reg, q_reg;
    logic [WIDE_W-1:0] d_shl;
    logic              can_shift, sub_ok;

    assign d_shl     = {d_reg[WIDE_W-2:0], 1'b0};
    assign can_shift = !d_reg[WIDE_W-1] && (d_shl <= r_reg);
    assign sub_ok    = (r_reg >= d_reg);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                    state_next = D_ALIGN;
            end
            D_ALIGN:
            begin
                if (!can_shift)
                    state_next = D_REDUCE;
            end
            D_REDUCE:
            begin
                if (k_reg == '0)
                begin
                    state_next = D_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    r_reg <= dividend;
                    d_reg <= divisor;
                    q_reg <= '0;
                    k_reg <= '0;
                end
            end
            D_ALIGN:
            begin
                if (can_shift)
                begin
                    d_reg <= d_shl;
                    k_reg <= k_reg + 1'b1;
                end
            end
            D_REDUCE:
            begin
                if (sub_ok)
                    r_reg <= r_reg - d_reg;
                q_reg <= {q_reg[WIDE_W-2:0], sub_ok};
                if (k_reg != '0)
                begin
                    d_reg <= {1'b0, d_reg[WIDE_W-1:1]};
                    k_reg <= k_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

FILE: hdl/rau_datapath.sv
module rau_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [127:0]                   s_tdata,
    input  logic [1:0]                     s_tuser,
    input  rau_pkg::cmd_t                  cmd,
    output rau_pkg::sts_t                  sts,
    output logic [63:0]                    m_tdata,
    output logic [1:0]                     m_tuser
);
    import rau_pkg::*;

    logic [1:0]        op_reg;
    operand_t          an_reg, ad_reg, bn_reg, bd_reg;
    logic [WIDE_W-1:0] p0_reg, p1_reg, p2_reg;
    logic              s0_reg, s1_reg, s2_reg;
    logic [WIDE_W-1:0] n_mag_reg, d_mag_reg, x_reg, y_reg, g_mag_reg, qn_reg, qd_reg;
    logic              n_neg_reg, d_neg_reg, g_neg_reg, odd_reg;
    logic [FIELD_W-1:0] res_num_reg, res_den_reg;
    logic [1:0]        status_reg;

    logic [FIELD_W-1:0] mul_a, mul_b;
    logic               mul_s;
    logic [WIDE_W-1:0]  mul_p;

    logic               a_neg, b_neg;
    logic [WIDE_W-1:0]  sum_mag;
    logic               sum_neg;
    logic [WIDE_W-1:0]  n_mag_c;
    logic               n_neg_c;

    logic [WIDE_W-1:0]  div_dvd, div_dvs, div_q, div_r;
    logic               div_done;

    logic               rn_neg, rd_neg, fit_n, fit_d;
    logic [WIDE_W-1:0]  fn, fd;

    // multiplier operand select
    always_comb
    begin
        mul_a = an_reg.mag;
        mul_b = bd_reg.mag;
        mul_s = an_reg.neg ^ bd_reg.neg;
        case (cmd.mul_step)
            MUL_S0:
            begin
                mul_a = an_reg.mag;
                mul_b = (op_reg == OP_MUL) ? bn_reg.mag : bd_reg.mag;
                mul_s = an_reg.neg ^ ((op_reg == OP_MUL) ? bn_reg.neg : bd_reg.neg);
            end
            MUL_S1:
            begin
                mul_a = bn_reg.mag;
                mul_b = ad_reg.mag;
                mul_s = bn_reg.neg ^ ad_reg.neg ^ (op_reg == OP_SUB);
            end
            MUL_S2:
            begin
                mul_a = ad_reg.mag;
                mul_b = (op_reg == OP_DIV) ? bn_reg.mag : bd_reg.mag;
                mul_s = ad_reg.neg ^ ((op_reg == OP_DIV) ? bn_reg.neg : bd_reg.neg);
            end
            default: ;
        endcase
    end

    assign mul_p = WIDE_W'(mul_a) * WIDE_W'(mul_b);

    // signed add of the two cross products
    assign a_neg = s0_reg && (p0_reg != '0);
    assign b_neg = s1_reg && (p1_reg != '0);

    always_comb
    begin
        if (a_neg == b_neg)
        begin
            sum_mag = p0_reg + p1_reg;
            sum_neg = a_neg;
        end
        else if (p0_reg >= p1_reg)
        begin
            sum_mag = p0_reg - p1_reg;
            sum_neg = a_neg;
        end
        else
        begin
            sum_mag = p1_reg - p0_reg;
            sum_neg = b_neg;
        end
        if (sum_mag == '0)
            sum_neg = 1'b0;
    end

    assign n_mag_c = (op_reg == OP_ADD || op_reg == OP_SUB) ? sum_mag : p0_reg;
    assign n_neg_c = (op_reg == OP_ADD || op_reg == OP_SUB) ? sum_neg : a_neg;

    // shared divider: Euclid remainders, then the two reductions
    always_comb
    begin
        div_dvd = y_reg;
        div_dvs = x_reg;
        case (cmd.div_sel)
            DIV_EUC:
            begin
                div_dvd = y_reg;
                div_dvs = x_reg;
            end
            DIV_NUM:
            begin
                div_dvd = n_mag_reg;
                div_dvs = g_mag_reg;
            end
            DIV_DEN:
            begin
                div_dvd = d_mag_reg;
                div_dvs = g_mag_reg;
            end
            default: ;
        endcase
    end

    rau_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // range check and field conversion
    assign rn_neg = (qn_reg != '0) && (n_neg_reg != g_neg_reg);
    assign rd_neg = (qd_reg != '0) && (d_neg_reg != g_neg_reg);
    assign fit_n  = rn_neg ? (qn_reg <= FIT_LIM) : (qn_reg < FIT_LIM);
    assign fit_d  = rd_neg ? (qd_reg <= FIT_LIM) : (qd_reg < FIT_LIM);
    assign fn     = rn_neg ? (~qn_reg + 1'b1) : qn_reg;
    assign fd     = rd_neg ? (~qd_reg + 1'b1) : qd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= s_tuser;
            an_reg <= load_operand(s_tdata[31:0]);
            ad_reg <= load_operand(s_tdata[63:32]);
            bn_reg <= load_operand(s_tdata[95:64]);
            bd_reg <= load_operand(s_tdata[127:96]);
        end
        if (cmd.mul_load)
        begin
            case (cmd.mul_step)
                MUL_S0:
                begin
                    p0_reg <= mul_p;
                    s0_reg <= mul_s;
                end
                MUL_S1:
                begin
                    p1_reg <= mul_p;
                    s1_reg <= mul_s;
                end
                MUL_S2:
                begin
                    p2_reg <= mul_p;
                    s2_reg <= mul_s;
                end
                default: ;
            endcase
        end
        if (cmd.comb_load)
        begin
            n_mag_reg <= n_mag_c;
            n_neg_reg <= n_neg_c;
            d_mag_reg <= p2_reg;
            d_neg_reg <= s2_reg && (p2_reg != '0);
            x_reg     <= n_mag_c;
            y_reg     <= p2_reg;
            odd_reg   <= 1'b1;
        end
        if (cmd.euc_step)
        begin
            y_reg   <= x_reg;
            x_reg   <= div_r;
            odd_reg <= !odd_reg;
        end
        if (cmd.g_load)
        begin
            g_mag_reg <= y_reg;
            g_neg_reg <= odd_reg ? d_neg_reg : n_neg_reg;
        end
        if (cmd.qn_load)
            qn_reg <= div_q;
        if (cmd.qd_load)
            qd_reg <= div_q;
        if (cmd.out_load)
        begin
            if (cmd.out_gz)
            begin
                res_num_reg <= '0;
                res_den_reg <= '0;
                status_reg  <= ST_GZERO;
            end
            else if (!fit_n || !fit_d)
            begin
                res_num_reg <= '0;
                res_den_reg <= '0;
                status_reg  <= ST_OVF;
            end
            else
            begin
                res_num_reg <= fn[FIELD_W-1:0];
                res_den_reg <= fd[FIELD_W-1:0];
                status_reg  <= ST_OK;
            end
        end
    end

    assign sts.x_zero   = (x_reg == '0);
    assign sts.y_zero   = (y_reg == '0);
    assign sts.div_done = div_done;

    assign m_tdata = {res_den_reg, res_num_reg};
    assign m_tuser = status_reg;

endmodule

FILE: hdl/rau_ctrl.sv
module rau_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  rau_pkg::sts_t  sts,
    output rau_pkg::cmd_t  cmd
);
    import rau_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL0 = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_MUL2 = 4'd3;
    localparam logic [3:0] S_COMB = 4'd4;
    localparam logic [3:0] S_EUC  = 4'd5;
    localparam logic [3:0] S_EUCW = 4'd6;
    localparam logic [3:0] S_QN   = 4'd7;
    localparam logic [3:0] S_QNW  = 4'd8;
    localparam logic [3:0] S_QDW  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;
    localparam logic [3:0] S_FGZ  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       out_free;

    assign out_free = !ovalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_step = MUL_S0;
        cmd.div_sel  = DIV_EUC;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_step = MUL_S0;
                state_next   = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_step = MUL_S1;
                state_next   = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_step = MUL_S2;
                state_next   = S_COMB;
            end
            S_COMB:
            begin
                cmd.comb_load = 1'b1;
                state_next    = S_EUC;
            end
            S_EUC:
            begin
                if (sts.x_zero)
                begin
                    if (sts.y_zero)
                        state_next = S_FGZ;
                    else
                    begin
                        cmd.g_load = 1'b1;
                        state_next = S_QN;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_EUC;
                    state_next    = S_EUCW;
                end
            end
            S_EUCW:
            begin
                if (sts.div_done)
                begin
                    cmd.euc_step = 1'b1;
                    state_next   = S_EUC;
                end
            end
            S_QN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_NUM;
                state_next    = S_QNW;
            end
            S_QNW:
            begin
                if (sts.div_done)
                begin
                    cmd.qn_load   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_DEN;
                    state_next    = S_QDW;
                end
            end
            S_QDW:
            begin
                if (sts.div_done)
                begin
                    cmd.qd_load = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FGZ:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_gz   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.out_load)
            ovalid_next = 1'b1;
        else if (m_tready)
            ovalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = ovalid_reg;

endmodule

FILE: hdl/rational_arithmetic_unit_top.sv
// The three multiplies and the combine come first, then the Euclid loop, then the two reductions.
//   Each Euclid step and each reduction runs on the one shift-subtract divider.
// A new transaction is taken only after the last one has been loaded into the output register;
//   the divider, shared by Euclid and the final reductions, sets how long that takes (data dependent).
// A new input is taken while a finished result still waits in the output register.
// Reset (rst_n, async, active low) returns the controller to idle, output invalid.
module rational_arithmetic_unit_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_num, a_den, b_num, b_den (32 bits each)
    input  logic [1:0]   s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // res_num, res_den (32 bits each)
    output logic [1:0]   m_tuser    // status
);
    import rau_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // controller: sequence multiplies, Euclid loop and reductions
    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: operand registers, multiplier, adder, shared divider, output register
    rau_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .sts     (sts),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

FILE: hdl/rau_checker.sv
module rau_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [1:0]   m_tuser
);
    import rau_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_GZERO || m_tuser == ST_OVF) |-> m_tdata == '0)
        else $error("nonzero fields with error status");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_GZERO || m_tuser == ST_OVF))
        else $error("bad status code");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after accept");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
